@@ src/fpft_pkg.sv @@
// fpft_pkg: shared types and constants of the fifo page-frame tracker
// no dependencies; used by the interfaces, controller, datapath and top level

package fpft_pkg;

    // fixed widths of the response fields
    localparam int FRAME_W  = 2;
    localparam int OFFSET_W = 10;
    localparam int PAGE_W   = 14;
    localparam int COUNT_W  = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the incoming element index
        logic commit;    // do the lookup, update frames and load the result
    } t_ctrl_cmd;

endpackage

@@ src/fpft_if.sv @@
// fpft_if: request and response channels of the fifo page-frame tracker
// depends on fpft_pkg for the response field widths

interface fpft_req_if #(
    parameter int INDEX_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] elem_index;

    modport source (output valid, output elem_index, input ready);
    modport sink   (input valid, input elem_index, output ready);
endinterface

interface fpft_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [fpft_pkg::FRAME_W-1:0]  frame;
    logic [fpft_pkg::OFFSET_W-1:0] offset;
    logic [fpft_pkg::PAGE_W-1:0]   page_number;
    logic                         evict_valid;
    logic [fpft_pkg::PAGE_W-1:0]   evict_page;
    logic [fpft_pkg::COUNT_W-1:0]  hit_total;
    logic [fpft_pkg::COUNT_W-1:0]  fault_total;

    modport source (
        output valid, output hit, output frame, output offset, output page_number,
        output evict_valid, output evict_page, output hit_total, output fault_total,
        input  ready
    );
    modport sink (
        input  valid, input hit, input frame, input offset, input page_number,
        input  evict_valid, input evict_page, input hit_total, input fault_total,
        output ready
    );
endinterface

@@ src/fpft_ctrl.sv @@
// fpft_ctrl: sequencing of requests through capture and lookup
// depends on fpft_pkg for the command struct

module fpft_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fpft_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // result register can take a new value this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // commands to the datapath
    always_comb begin
        o_cmd.capture = i_in_valid && (r_state == S_IDLE);
        o_cmd.commit  = (r_state == S_LOOK) && out_free;
    end

    // next state and next result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/fpft_datapath.sv @@
// fpft_datapath: index split, frame lookup, fifo replacement, counters, result register
// depends on fpft_pkg for field widths and the command struct

module fpft_datapath #(
    parameter int PAGE_WORDS  = 1024,
    parameter int FRAME_COUNT = 4,
    parameter int INDEX_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpft_pkg::t_ctrl_cmd           i_cmd,
    input  logic [INDEX_BITS-1:0]         i_elem_index,
    output logic                          o_hit,
    output logic [fpft_pkg::FRAME_W-1:0]  o_frame,
    output logic [fpft_pkg::OFFSET_W-1:0] o_offset,
    output logic [fpft_pkg::PAGE_W-1:0]   o_page_number,
    output logic                          o_evict_valid,
    output logic [fpft_pkg::PAGE_W-1:0]   o_evict_page,
    output logic [fpft_pkg::COUNT_W-1:0]  o_hit_total,
    output logic [fpft_pkg::COUNT_W-1:0]  o_fault_total
);

    // page size is a power of two, so the split is a shift and a mask
    localparam int OFF_BITS   = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam int TAG_RAW    = INDEX_BITS - OFF_BITS;
    localparam int TAG_BITS   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

    logic [INDEX_BITS-1:0]        r_index;
    logic [TAG_BITS-1:0]          r_tag [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]       r_used;
    logic [FRAME_BITS-1:0]        r_oldest;
    logic [fpft_pkg::COUNT_W-1:0] r_hits;
    logic [fpft_pkg::COUNT_W-1:0] r_faults;

    logic [TAG_BITS-1:0]          page;
    logic [OFF_BITS-1:0]          offset;
    logic                         hit_found;
    logic [FRAME_BITS-1:0]        hit_slot;
    logic                         free_found;
    logic [FRAME_BITS-1:0]        free_slot;
    logic                         evict;
    logic [FRAME_BITS-1:0]        slot;
    logic [TAG_BITS-1:0]          victim;
    logic [FRAME_BITS:0]          oldest_inc;
    logic [FRAME_BITS-1:0]        n_oldest;
    logic [fpft_pkg::COUNT_W-1:0] n_hits;
    logic [fpft_pkg::COUNT_W-1:0] n_faults;

    // split the captured index into page and offset
    assign page   = TAG_BITS'(r_index >> OFF_BITS);
    assign offset = OFF_BITS'(r_index);

    // parallel tag compare, lowest matching frame wins
    always_comb begin
        hit_found = 1'b0;
        hit_slot  = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!hit_found && r_used[i] && (r_tag[i] == page)) begin
                hit_found = 1'b1;
                hit_slot  = FRAME_BITS'(i);
            end
        end
    end

    // lowest free frame
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!free_found && !r_used[i]) begin
                free_found = 1'b1;
                free_slot  = FRAME_BITS'(i);
            end
        end
    end

    // slot choice, victim, fifo pointer advance and next counter values
    always_comb begin
        evict      = !hit_found && !free_found;
        victim     = r_tag[r_oldest];
        oldest_inc = {1'b0, r_oldest} + 1'b1;
        if (hit_found) begin
            slot = hit_slot;
        end else if (free_found) begin
            slot = free_slot;
        end else begin
            slot = r_oldest;
        end
        n_oldest = r_oldest;
        if (evict) begin
            n_oldest = (oldest_inc == (FRAME_BITS+1)'(FRAME_COUNT)) ? '0
                                                                  : oldest_inc[FRAME_BITS-1:0];
        end
        n_hits   = hit_found ? r_hits + 1'b1 : r_hits;
        n_faults = hit_found ? r_faults : r_faults + 1'b1;
    end

    // capture of the request index
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_index <= i_elem_index;
        end
    end

    // resident frames, fifo pointer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_tag[i] <= '0;
            end
            r_used   <= '0;
            r_oldest <= '0;
            r_hits   <= '0;
            r_faults <= '0;
        end else if (i_cmd.commit) begin
            if (!hit_found) begin
                r_tag[slot]  <= page;
                r_used[slot] <= 1'b1;
            end
            r_oldest <= n_oldest;
            r_hits   <= n_hits;
            r_faults <= n_faults;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit         <= hit_found;
            o_frame       <= fpft_pkg::FRAME_W'(slot);
            o_offset      <= fpft_pkg::OFFSET_W'(offset);
            o_page_number <= fpft_pkg::PAGE_W'(page);
            o_evict_valid <= evict;
            o_evict_page  <= evict ? fpft_pkg::PAGE_W'(victim) : '0;
            o_hit_total   <= n_hits;
            o_fault_total <= n_faults;
        end
    end

endmodule

@@ src/fifo_page_frame_tracker.sv @@
// fifo_page_frame_tracker: top level of the fifo page-frame tracker
// depends on fpft_pkg, fpft_if, fpft_ctrl and fpft_datapath
//
//   channel  direction  payload                                     accepted when
//   i_req    in         elem_index                                  valid && ready
//   o_rsp    out        hit, frame, offset, page_number,            valid && ready
//                       evict_valid, evict_page, hit_total, fault_total
//
// each request passes through capture of the index and then the frame
// compare, replacement and counter update in the datapath.
// the lookup cycle waits while the result register is full and not taken;
// a new request is taken while an earlier result still waits.
// reset is synchronous, active low, and clears frames, fifo pointer and counters.
// PAGE_WORDS must be a power of two.

module fifo_page_frame_tracker #(
    parameter int PAGE_WORDS  = 1024,
    parameter int FRAME_COUNT = 4,
    parameter int INDEX_BITS  = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpft_req_if.sink  i_req,
    fpft_rsp_if.source o_rsp
);

    fpft_pkg::t_ctrl_cmd cmd;

    // controller
    fpft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // datapath
    fpft_datapath #(
        .PAGE_WORDS  (PAGE_WORDS),
        .FRAME_COUNT (FRAME_COUNT),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_elem_index  (i_req.elem_index),
        .o_hit         (o_rsp.hit),
        .o_frame       (o_rsp.frame),
        .o_offset      (o_rsp.offset),
        .o_page_number (o_rsp.page_number),
        .o_evict_valid (o_rsp.evict_valid),
        .o_evict_page  (o_rsp.evict_page),
        .o_hit_total   (o_rsp.hit_total),
        .o_fault_total (o_rsp.fault_total)
    );

endmodule

@@ src/fpft_checker.sv @@
// fpft_checker: port-level checks of the fifo page-frame tracker
// depends on fpft_pkg; bound to fifo_page_frame_tracker at the end of this file

module fpft_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_hit,
    input logic                          i_evict_valid,
    input logic [fpft_pkg::PAGE_W-1:0]   i_evict_page,
    input logic [fpft_pkg::COUNT_W-1:0]  i_hit_total,
    input logic [fpft_pkg::COUNT_W-1:0]  i_fault_total
);

    logic                         r_seen;
    logic [fpft_pkg::COUNT_W-1:0] r_sum;

    // running total of the last response taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_sum  <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen <= 1'b1;
            r_sum  <= i_hit_total + i_fault_total;
        end
    end

    // no response straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // a stalled response holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit)
            && $stable(i_evict_valid) && $stable(i_hit_total) && $stable(i_fault_total))
        else $error("stalled response changed");

    // a hit never evicts, and a response without an eviction reports a zero page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hit && i_evict_valid) && (i_evict_valid || i_evict_page == '0))
        else $error("inconsistent eviction fields");

    // each response advances hits plus faults by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen |-> (i_hit_total + i_fault_total) == (r_sum + 1'b1))
        else $error("counters did not advance by one");

endmodule

bind fifo_page_frame_tracker fpft_checker u_fpft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_hit         (o_rsp.hit),
    .i_evict_valid (o_rsp.evict_valid),
    .i_evict_page  (o_rsp.evict_page),
    .i_hit_total   (o_rsp.hit_total),
    .i_fault_total (o_rsp.fault_total)
);

@@ sim/tb_fifo_page_frame_tracker.sv @@
// tb_fifo_page_frame_tracker: self-checking bench for the fifo page-frame tracker
// depends on fpft_pkg, fpft_if and fifo_page_frame_tracker; predicts every response
// from its own frame model and compares it field by field under random back-pressure

module tb_fifo_page_frame_tracker;

    localparam int PAGE_WORDS  = 1024;
    localparam int FRAME_COUNT = 4;
    localparam int INDEX_BITS  = 24;
    localparam int POOL_N      = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // one expected response
    typedef struct packed {
        logic                          hit;
        logic [fpft_pkg::FRAME_W-1:0]  frame;
        logic [fpft_pkg::OFFSET_W-1:0] offset;
        logic [fpft_pkg::PAGE_W-1:0]   page_number;
        logic                          evict_valid;
        logic [fpft_pkg::PAGE_W-1:0]   evict_page;
        logic [fpft_pkg::COUNT_W-1:0]  hit_total;
        logic [fpft_pkg::COUNT_W-1:0]  fault_total;
    } t_lookup;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpft_req_if #(.INDEX_BITS(INDEX_BITS)) req_ch ();
    fpft_rsp_if rsp_ch ();

    fifo_page_frame_tracker #(
        .PAGE_WORDS (PAGE_WORDS),
        .FRAME_COUNT(FRAME_COUNT),
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // frame model state
    logic [fpft_pkg::PAGE_W-1:0]  frame_pg   [FRAME_COUNT];
    logic                         frame_busy [FRAME_COUNT];
    int                           fifo_head;
    logic [fpft_pkg::COUNT_W-1:0] hit_cnt;
    logic [fpft_pkg::COUNT_W-1:0] fault_cnt;

    // pending indices and responses still owed by the block
    logic [INDEX_BITS-1:0] index_q [$];
    t_lookup               lookup_q [$];

    // working set of pages for the random part
    logic [fpft_pkg::PAGE_W-1:0] page_pool [POOL_N];

    int  send_gap_pct;
    int  take_gap_pct;
    bit  req_taken;
    bit  hold_go;
    int  hold_left;
    int  cycle_cnt;
    int  mismatch_cnt;
    int  req_cnt;
    int  hits_seen;
    int  faults_seen;
    int  evicts_seen;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // page lookup with fifo replacement; updates the frame model
    function automatic t_lookup lookup_page(input logic [INDEX_BITS-1:0] idx);
        t_lookup               r;
        logic [INDEX_BITS-1:0] pg;
        int                    slot;
        bit                    found;
        bit                    placed;
        r      = '0;
        pg     = INDEX_BITS'(idx / PAGE_WORDS);
        slot   = 0;
        found  = 1'b0;
        placed = 1'b0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!found && frame_busy[i] && frame_pg[i] == pg[fpft_pkg::PAGE_W-1:0]) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            hit_cnt = hit_cnt + 1;
        end else begin
            // lowest free frame first, then the oldest loaded one
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!placed && !frame_busy[i]) begin
                    placed = 1'b1;
                    slot   = i;
                end
            end
            if (!placed) begin
                slot          = fifo_head;
                r.evict_valid = 1'b1;
                r.evict_page  = frame_pg[slot];
                fifo_head     = (slot + 1 == FRAME_COUNT) ? 0 : slot + 1;
            end
            frame_pg[slot]   = pg[fpft_pkg::PAGE_W-1:0];
            frame_busy[slot] = 1'b1;
            fault_cnt        = fault_cnt + 1;
        end
        r.hit         = found;
        r.frame       = slot[fpft_pkg::FRAME_W-1:0];
        r.offset      = idx[fpft_pkg::OFFSET_W-1:0];
        r.page_number = pg[fpft_pkg::PAGE_W-1:0];
        r.hit_total   = hit_cnt;
        r.fault_total = fault_cnt;
        return r;
    endfunction

    // fresh page for the working set, now and then an extreme one
    function automatic logic [fpft_pkg::PAGE_W-1:0] pick_page();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else
            return fpft_pkg::PAGE_W'($urandom_range((1 << fpft_pkg::PAGE_W) - 1));
    endfunction

    // random index: mostly the working set, some wide noise, some extremes
    function automatic logic [INDEX_BITS-1:0] next_index();
        int                            sel;
        logic [fpft_pkg::PAGE_W-1:0]   pg;
        logic [fpft_pkg::OFFSET_W-1:0] off;
        sel = $urandom_range(99);
        if ($urandom_range(39) == 0)
            page_pool[$urandom_range(POOL_N - 1)] = pick_page();
        off = fpft_pkg::OFFSET_W'($urandom_range(PAGE_WORDS - 1));
        if (sel < 75) begin
            pg = page_pool[$urandom_range(POOL_N - 1)];
        end else if (sel < 92) begin
            return INDEX_BITS'($urandom);
        end else begin
            pg  = $urandom_range(1) ? '0 : '1;
            off = $urandom_range(1) ? '0 : '1;
        end
        return {pg, off};
    endfunction

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
            index_q = {index_q, next_index()};
    endtask

    task automatic push_page(input logic [fpft_pkg::PAGE_W-1:0] pg,
                             input logic [fpft_pkg::OFFSET_W-1:0] off);
        index_q = {index_q, {pg, off}};
    endtask

    // wait until every request is sent and every response has come back
    task automatic drain();
        while (index_q.size() != 0 || req_ch.valid || lookup_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [fpft_pkg::COUNT_W-1:0] want,
                               input logic [fpft_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (index_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                req_ch.valid      <= 1'b1;
                req_ch.elem_index <= index_q[0];
                index_q.delete(0);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left != 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
            hold_go   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: predict on each request, check each response
    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                lookup_q = {lookup_q, lookup_page(req_ch.elem_index)};
                req_taken = 1'b1;
                req_cnt++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.hit, rsp_ch.frame, rsp_ch.offset, rsp_ch.page_number,
                        rsp_ch.evict_valid, rsp_ch.evict_page, rsp_ch.hit_total,
                        rsp_ch.fault_total};
                if (lookup_q.size() == 0) begin
                    $error("response with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = lookup_q[0];
                    lookup_q.delete(0);
                    check_field("hit", fpft_pkg::COUNT_W'(want.hit),
                                fpft_pkg::COUNT_W'(got.hit));
                    check_field("frame", fpft_pkg::COUNT_W'(want.frame),
                                fpft_pkg::COUNT_W'(got.frame));
                    check_field("offset", fpft_pkg::COUNT_W'(want.offset),
                                fpft_pkg::COUNT_W'(got.offset));
                    check_field("page_number", fpft_pkg::COUNT_W'(want.page_number),
                                fpft_pkg::COUNT_W'(got.page_number));
                    check_field("evict_valid", fpft_pkg::COUNT_W'(want.evict_valid),
                                fpft_pkg::COUNT_W'(got.evict_valid));
                    check_field("evict_page", fpft_pkg::COUNT_W'(want.evict_page),
                                fpft_pkg::COUNT_W'(got.evict_page));
                    check_field("hit_total", want.hit_total, got.hit_total);
                    check_field("fault_total", want.fault_total, got.fault_total);
                    if (want.hit)
                        hits_seen++;
                    else
                        faults_seen++;
                    if (want.evict_valid)
                        evicts_seen++;
                end
            end
        end
    end

    // stimulus and phase control
    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.elem_index = '0;
        rsp_ch.ready      = 1'b0;
        req_taken         = 1'b0;
        hold_go           = 1'b0;
        hold_left         = 0;
        cycle_cnt         = 0;
        mismatch_cnt      = 0;
        req_cnt           = 0;
        hits_seen         = 0;
        faults_seen       = 0;
        evicts_seen       = 0;
        fifo_head         = 0;
        hit_cnt           = '0;
        fault_cnt         = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            frame_pg[i]   = '0;
            frame_busy[i] = 1'b0;
        end
        for (int i = 0; i < POOL_N; i++)
            page_pool[i] = pick_page();
        send_gap_pct = 25;
        take_gap_pct = 87;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // page 0 misses although the tags reset to zero, then hits
        push_page(14'd0, 10'd0);
        push_page(14'd0, 10'd1023);
        // fill the remaining free frames in order
        push_page(14'h3fff, 10'h3ff);
        push_page(14'd1, 10'd0);
        push_page(14'h2000, 10'h200);
        // a hit on the oldest page must not reorder the fifo
        push_page(14'd0, 10'd5);
        // all frames full: evictions walk the frames and wrap round
        push_page(14'd5, 10'd7);
        push_page(14'd0, 10'd9);
        push_page(14'h2000, 10'd3);
        push_page(14'd2, 10'h155);
        push_page(14'd3, 10'h2aa);
        push_page(14'd4, 10'd0);
        push_page(14'h2aaa, 10'h2aa);
        push_page(14'h1555, 10'h155);
        push_page(14'd4, 10'h3ff);
        push_page(14'h3fff, 10'd0);
        push_page(14'd0, 10'd0);

        // sender idles a quarter of the time, receiver mostly stalls
        push_random(620);
        drain();

        // swapped idling
        send_gap_pct = 87;
        take_gap_pct = 25;
        push_random(620);
        drain();

        // no idling, with one long receiver hold-off while requests keep coming
        send_gap_pct = 0;
        take_gap_pct = 0;
        push_random(660);
        @(negedge i_clk);
        hold_go = 1'b1;
        drain();

        repeat (8) @(posedge i_clk);
        $display("%0d requests checked: %0d hits, %0d faults, %0d evictions",
                 req_cnt, hits_seen, faults_seen, evicts_seen);
        $display("idling phases sender/receiver 25/87, 87/25, 0/0, with a %0d-cycle stall",
                 HOLD_CYCLES);
        if (mismatch_cnt == 0 && lookup_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
